>>> sv/tmtc_pkg.sv
// Shared types, constants and register indexes of the traction mode torque command block.
`default_nettype none
package tmtc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int DVD_W = 29;
   localparam int DVS_W = 23;
   localparam int CNT_W = $clog2(DVD_W);
   localparam int CSR_INDEX_W = 3;

   localparam logic [9:0] THROTTLE_SPLIT = 10'd100;
   localparam logic [15:0] BRAKE_MIN_SPEED = 16'd1200;
   localparam logic [12:0] POWER_NUM = 13'd4522;
   localparam logic [6:0] POWER_DEN = 7'd100;

   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_POWER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_REGEN_TORQUE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGEN_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_SPEED_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_REGEN_BRAKE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CREEP_SPEED_THRESHOLD = 3'd5;

   localparam logic [15:0] RESET_BRAKE_POWER = 16'd30000;
   localparam logic [15:0] RESET_MAX_REGEN_TORQUE = 16'd1000;

   typedef enum logic [1:0] {
      DS_NEUTRAL = 2'd0,
      DS_BRAKE   = 2'd1,
      DS_ACCEL   = 2'd2,
      DS_DISABLE = 2'd3
   } drive_state_type;

   typedef struct packed {
      logic [15:0] brake_power;
      logic [15:0] max_regen_torque;
      logic        regen_enable;
      logic [15:0] mode_speed_limit;
      logic        mode_regen_brake;
      logic [15:0] creep_speed_threshold;
   } cfg_type;

   typedef struct packed {
      drive_state_type   drive_state;
      logic              enable_bit;
      logic              brake_bit;
      logic              run_bit;
      logic [15:0]       torque_right;
      logic [15:0]       torque_left;
      logic [15:0]       speed_reference;
      logic              need_div;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } job_type;

   typedef struct packed {
      drive_state_type drive_state;
      logic            enable_bit;
      logic            brake_bit;
      logic            run_bit;
      logic [15:0]     torque_right;
      logic [15:0]     torque_left;
      logic [15:0]     negative_torque;
      logic [15:0]     speed_reference;
   } rsp_type;

endpackage
`default_nettype wire

>>> sv/tmtc_front.sv
// Front end: accepts a tick, picks the drive state, keeps the held torques and forms the job.
`default_nettype none
module tmtc_front (
   input  wire                    clock,
   input  wire                    reset,
   input  tmtc_pkg::cfg_type      cfg,
   input  wire                    push,
   output logic                   full,
   input  wire                    disable_req,
   input  wire                    new_reference,
   input  wire  [15:0]            torque_in_right,
   input  wire  [15:0]            torque_in_left,
   input  wire  [9:0]             throttle,
   input  wire  [15:0]            rear_mean_speed,
   input  wire  [15:0]            motor_speed_left,
   input  wire  [15:0]            motor_speed_right,
   input  wire  [15:0]            wheel_speed_right,
   input  wire  [15:0]            wheel_speed_left,
   input  wire                    queue_full,
   output logic                   queue_push,
   output tmtc_pkg::job_type      queue_data
);

   logic [15:0] held_right_ff, held_right_in;
   logic [15:0] held_left_ff, held_left_in;
   logic [15:0] torque_sel_right, torque_sel_left;
   logic [15:0] speed_max;
   tmtc_pkg::drive_state_type state_sel;
   tmtc_pkg::job_type job;

   assign full = queue_full;
   assign queue_push = push && !queue_full;

   always_comb begin
      torque_sel_right = new_reference ? torque_in_right : held_right_ff;
      torque_sel_left  = new_reference ? torque_in_left : held_left_ff;
      speed_max = (motor_speed_left > motor_speed_right) ? motor_speed_left : motor_speed_right;

      if (disable_req) begin
         state_sel = tmtc_pkg::DS_DISABLE;
      end else if (throttle < tmtc_pkg::THROTTLE_SPLIT && cfg.regen_enable
                   && rear_mean_speed > tmtc_pkg::BRAKE_MIN_SPEED) begin
         state_sel = tmtc_pkg::DS_BRAKE;
      end else if (throttle > tmtc_pkg::THROTTLE_SPLIT) begin
         state_sel = tmtc_pkg::DS_ACCEL;
      end else begin
         state_sel = tmtc_pkg::DS_NEUTRAL;
      end

      job = '0;
      job.drive_state = state_sel;
      job.enable_bit = 1'b1;
      job.dividend = tmtc_pkg::DVD_W'(cfg.brake_power) * tmtc_pkg::DVD_W'(tmtc_pkg::POWER_NUM);
      job.divisor = tmtc_pkg::DVS_W'(speed_max) * tmtc_pkg::DVS_W'(tmtc_pkg::POWER_DEN);
      case (state_sel)
         tmtc_pkg::DS_NEUTRAL: begin
            job.run_bit = (wheel_speed_right > cfg.creep_speed_threshold)
                          || (wheel_speed_left > cfg.creep_speed_threshold);
            job.speed_reference = cfg.mode_speed_limit;
         end
         tmtc_pkg::DS_BRAKE: begin
            job.brake_bit = cfg.mode_regen_brake;
            job.run_bit = 1'b1;
            job.need_div = (speed_max != 16'd0);
         end
         tmtc_pkg::DS_ACCEL: begin
            job.run_bit = 1'b1;
            job.speed_reference = cfg.mode_speed_limit;
            job.torque_right = torque_sel_right;
            job.torque_left = torque_sel_left;
         end
         default: begin
            job.enable_bit = 1'b0;
         end
      endcase
      queue_data = job;

      held_right_in = held_right_ff;
      held_left_in = held_left_ff;
      if (queue_push) begin
         held_right_in = job.torque_right;
         held_left_in = job.torque_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_right_ff <= '0;
         held_left_ff <= '0;
      end else begin
         held_right_ff <= held_right_in;
         held_left_ff <= held_left_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/tmtc_fifo.sv
// Short queue of classified jobs between the front end and the back end.
`default_nettype none
module tmtc_fifo #(
   parameter int DEPTH = tmtc_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                wr_en,
   input  tmtc_pkg::job_type  wr_data,
   output logic               wr_full,
   input  wire                rd_en,
   output tmtc_pkg::job_type  rd_data,
   output logic               rd_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tmtc_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign wr_full = (count_ff == CNT_W'(DEPTH));
   assign rd_empty = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr = wr_en && !wr_full;
   assign do_rd = rd_en && !rd_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

>>> sv/tmtc_div.sv
// Restoring divider that yields one quotient bit per cycle for the regenerative torque.
`default_nettype none
module tmtc_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [tmtc_pkg::DVD_W-1:0]   dividend,
   input  wire  [tmtc_pkg::DVS_W-1:0]   divisor,
   output logic                         busy,
   output logic [tmtc_pkg::DVD_W-1:0]   quotient
);

   localparam int NW = tmtc_pkg::DVD_W;
   localparam int DW = tmtc_pkg::DVS_W;

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [tmtc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [DW:0] trial;
   logic [DW+1:0] diff;
   logic fits;

   assign busy = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[NW-1]};
      diff = {1'b0, trial} - {2'b00, dvs_ff};
      fits = !diff[DW+1];
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = tmtc_pkg::CNT_W'(NW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

>>> sv/tmtc_back.sv
// Back end: takes jobs from the queue, runs the torque division and holds the finished result.
`default_nettype none
module tmtc_back (
   input  wire                    clock,
   input  wire                    reset,
   input  tmtc_pkg::cfg_type      cfg,
   input  wire                    queue_empty,
   input  tmtc_pkg::job_type      queue_data,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   output tmtc_pkg::rsp_type      rsp_data,
   input  wire                    rsp_pop
);

   typedef enum logic [2:0] {
      BK_IDLE   = 3'b001,
      BK_DIVIDE = 3'b010,
      BK_DONE   = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   tmtc_pkg::job_type job_ff, job_in;
   tmtc_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;
   logic div_start, div_busy;
   logic [tmtc_pkg::DVD_W-1:0] div_quotient;
   logic [15:0] neg_clamped;

   tmtc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (queue_data.dividend),
      .divisor  (queue_data.divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
   assign out_free = !out_valid_ff || rsp_pop;

   always_comb begin
      neg_clamped = (div_quotient > tmtc_pkg::DVD_W'(cfg.max_regen_torque))
                    ? cfg.max_regen_torque : div_quotient[15:0];
      state_in = state_ff;
      job_in = job_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      queue_pop = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty && out_free) begin
               queue_pop = 1'b1;
               if (queue_data.need_div) begin
                  div_start = 1'b1;
                  job_in = queue_data;
                  state_in = BK_DIVIDE;
               end else begin
                  out_in.drive_state = queue_data.drive_state;
                  out_in.enable_bit = queue_data.enable_bit;
                  out_in.brake_bit = queue_data.brake_bit;
                  out_in.run_bit = queue_data.run_bit;
                  out_in.torque_right = queue_data.torque_right;
                  out_in.torque_left = queue_data.torque_left;
                  out_in.speed_reference = queue_data.speed_reference;
                  out_in.negative_torque = (queue_data.drive_state == tmtc_pkg::DS_BRAKE)
                                           ? cfg.max_regen_torque : 16'd0;
                  out_valid_in = 1'b1;
               end
            end
         end
         BK_DIVIDE: begin
            if (!div_busy) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_in.drive_state = job_ff.drive_state;
               out_in.enable_bit = job_ff.enable_bit;
               out_in.brake_bit = job_ff.brake_bit;
               out_in.run_bit = job_ff.run_bit;
               out_in.torque_right = job_ff.torque_right;
               out_in.torque_left = job_ff.torque_left;
               out_in.speed_reference = job_ff.speed_reference;
               out_in.negative_torque = neg_clamped;
               out_valid_in = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (state_ff == BK_IDLE && out_free))
      else $error("queue read outside the idle state or with the result register occupied");

   a_divide_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIVIDE && $past(state_ff) == BK_IDLE) |-> div_busy)
      else $error("divider not running after a division was started");

   a_neg_only_brake: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.drive_state != tmtc_pkg::DS_BRAKE) |-> out_ff.negative_torque == 16'd0)
      else $error("negative torque outside the brake state");

   a_neg_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE && out_free) |=> out_ff.negative_torque <= cfg.max_regen_torque)
      else $error("regenerative torque above the configured maximum");

endmodule
`default_nettype wire

>>> sv/traction_mode_torque_command.sv
// Top level of the traction mode torque command block: register file, front end, queue, back end.
// A tick needing the regenerative torque division passes through the queue, the divider and the
// result register; other ticks pass through the queue and the result register.
// The back end takes no new tick while the bit-serial divider works out its 29 quotient bits.
// Other ticks pass at up to one per cycle while no division runs and the results are popped.
// Synchronous reset empties the queue and result register, clears the held torques, loads defaults.
`default_nettype none
module traction_mode_torque_command #(
   parameter int QUEUE_DEPTH = tmtc_pkg::QUEUE_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                push,
   output logic                               full,
   input  wire                                req_disable_req,
   input  wire                                req_new_reference,
   input  wire  [15:0]                        req_torque_in_right,
   input  wire  [15:0]                        req_torque_in_left,
   input  wire  [9:0]                         req_throttle,
   input  wire  [15:0]                        req_rear_mean_speed,
   input  wire  [15:0]                        req_motor_speed_left,
   input  wire  [15:0]                        req_motor_speed_right,
   input  wire  [15:0]                        req_wheel_speed_right,
   input  wire  [15:0]                        req_wheel_speed_left,
   output logic                               empty,
   input  wire                                pop,
   output logic [1:0]                         rsp_drive_state,
   output logic                               rsp_enable_bit,
   output logic                               rsp_brake_bit,
   output logic                               rsp_run_bit,
   output logic [15:0]                        rsp_torque_out_right,
   output logic [15:0]                        rsp_torque_out_left,
   output logic [15:0]                        rsp_negative_torque,
   output logic [15:0]                        rsp_speed_reference,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [tmtc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [15:0]                        csr_wdata
);

   tmtc_pkg::cfg_type cfg_ff, cfg_in;
   tmtc_pkg::job_type front_data, queue_data;
   tmtc_pkg::rsp_type rsp_data;
   logic front_push, queue_full, queue_empty, queue_pop, rsp_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tmtc_pkg::CSR_BRAKE_POWER:           cfg_in.brake_power = csr_wdata;
            tmtc_pkg::CSR_MAX_REGEN_TORQUE:      cfg_in.max_regen_torque = csr_wdata;
            tmtc_pkg::CSR_REGEN_ENABLE:          cfg_in.regen_enable = csr_wdata[0];
            tmtc_pkg::CSR_MODE_SPEED_LIMIT:      cfg_in.mode_speed_limit = csr_wdata;
            tmtc_pkg::CSR_MODE_REGEN_BRAKE:      cfg_in.mode_regen_brake = csr_wdata[0];
            tmtc_pkg::CSR_CREEP_SPEED_THRESHOLD: cfg_in.creep_speed_threshold = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brake_power <= tmtc_pkg::RESET_BRAKE_POWER;
         cfg_ff.max_regen_torque <= tmtc_pkg::RESET_MAX_REGEN_TORQUE;
         cfg_ff.regen_enable <= 1'b0;
         cfg_ff.mode_speed_limit <= '0;
         cfg_ff.mode_regen_brake <= 1'b0;
         cfg_ff.creep_speed_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmtc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .push              (push),
      .full              (full),
      .disable_req       (req_disable_req),
      .new_reference     (req_new_reference),
      .torque_in_right   (req_torque_in_right),
      .torque_in_left    (req_torque_in_left),
      .throttle          (req_throttle),
      .rear_mean_speed   (req_rear_mean_speed),
      .motor_speed_left  (req_motor_speed_left),
      .motor_speed_right (req_motor_speed_right),
      .wheel_speed_right (req_wheel_speed_right),
      .wheel_speed_left  (req_wheel_speed_left),
      .queue_full        (queue_full),
      .queue_push        (front_push),
      .queue_data        (front_data)
   );

   tmtc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_push),
      .wr_data  (front_data),
      .wr_full  (queue_full),
      .rd_en    (queue_pop),
      .rd_data  (queue_data),
      .rd_empty (queue_empty)
   );

   tmtc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_pop     (pop)
   );

   assign empty = !rsp_valid;
   assign rsp_drive_state = rsp_data.drive_state;
   assign rsp_enable_bit = rsp_data.enable_bit;
   assign rsp_brake_bit = rsp_data.brake_bit;
   assign rsp_run_bit = rsp_data.run_bit;
   assign rsp_torque_out_right = rsp_data.torque_right;
   assign rsp_torque_out_left = rsp_data.torque_left;
   assign rsp_negative_torque = rsp_data.negative_torque;
   assign rsp_speed_reference = rsp_data.speed_reference;

endmodule
`default_nettype wire

>>> tb/tmtc_command_checker.sv
// Checker for the traction mode torque command block: predicts every command and compares it.
`timescale 1ns / 100ps
module tmtc_command_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             full,
   input  logic                             req_disable_req,
   input  logic                             req_new_reference,
   input  logic [15:0]                      req_torque_in_right,
   input  logic [15:0]                      req_torque_in_left,
   input  logic [9:0]                       req_throttle,
   input  logic [15:0]                      req_rear_mean_speed,
   input  logic [15:0]                      req_motor_speed_left,
   input  logic [15:0]                      req_motor_speed_right,
   input  logic [15:0]                      req_wheel_speed_right,
   input  logic [15:0]                      req_wheel_speed_left,
   input  logic                             empty,
   input  logic                             pop,
   input  logic [1:0]                       rsp_drive_state,
   input  logic                             rsp_enable_bit,
   input  logic                             rsp_brake_bit,
   input  logic                             rsp_run_bit,
   input  logic [15:0]                      rsp_torque_out_right,
   input  logic [15:0]                      rsp_torque_out_left,
   input  logic [15:0]                      rsp_negative_torque,
   input  logic [15:0]                      rsp_speed_reference,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [tmtc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_wdata,
   output int                               mismatch_count,
   output int                               outstanding
);

   tmtc_pkg::cfg_type settings;
   logic [15:0] held_right;
   logic [15:0] held_left;
   tmtc_pkg::rsp_type awaited_commands[$];
   tmtc_pkg::rsp_type seen;
   tmtc_pkg::rsp_type want;
   int faults = 0;

   assign mismatch_count = faults;

   function automatic logic [15:0] regen_torque(input logic [15:0] left, right);
      logic [15:0] fastest;
      logic [63:0] quotient;
      fastest = (left > right) ? left : right;
      if (fastest == 16'd0) return settings.max_regen_torque;
      quotient = (64'(settings.brake_power) * 64'(tmtc_pkg::POWER_NUM)) /
                 (64'(tmtc_pkg::POWER_DEN) * 64'(fastest));
      if (quotient > 64'(settings.max_regen_torque)) return settings.max_regen_torque;
      return quotient[15:0];
   endfunction

   function automatic tmtc_pkg::rsp_type command_for_tick();
      tmtc_pkg::rsp_type c;
      c = '0;
      c.enable_bit = 1'b1;
      if (req_new_reference) begin
         held_right = req_torque_in_right;
         held_left = req_torque_in_left;
      end
      if (req_disable_req)
         c.drive_state = tmtc_pkg::DS_DISABLE;
      else if (req_throttle < tmtc_pkg::THROTTLE_SPLIT && settings.regen_enable &&
               req_rear_mean_speed > tmtc_pkg::BRAKE_MIN_SPEED)
         c.drive_state = tmtc_pkg::DS_BRAKE;
      else if (req_throttle > tmtc_pkg::THROTTLE_SPLIT)
         c.drive_state = tmtc_pkg::DS_ACCEL;
      else
         c.drive_state = tmtc_pkg::DS_NEUTRAL;
      case (c.drive_state)
         tmtc_pkg::DS_NEUTRAL: begin
            c.run_bit = (req_wheel_speed_right > settings.creep_speed_threshold) ||
                        (req_wheel_speed_left > settings.creep_speed_threshold);
            c.speed_reference = settings.mode_speed_limit;
         end
         tmtc_pkg::DS_BRAKE: begin
            c.brake_bit = settings.mode_regen_brake;
            c.run_bit = 1'b1;
            c.negative_torque = regen_torque(req_motor_speed_left, req_motor_speed_right);
         end
         tmtc_pkg::DS_ACCEL: begin
            c.run_bit = 1'b1;
            c.speed_reference = settings.mode_speed_limit;
         end
         default: c.enable_bit = 1'b0;
      endcase
      if (c.drive_state != tmtc_pkg::DS_ACCEL) begin
         held_right = '0;
         held_left = '0;
      end
      c.torque_right = held_right;
      c.torque_left = held_left;
      return c;
   endfunction

   task automatic check_field(input string label, input logic [15:0] expected, actual);
      if (expected !== actual) begin
         faults++;
         if (faults <= 10)
            $display("%0t checker: %s expected %0d, got %0d", $realtime, label, expected,
                     actual);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings = '0;
         settings.brake_power = tmtc_pkg::RESET_BRAKE_POWER;
         settings.max_regen_torque = tmtc_pkg::RESET_MAX_REGEN_TORQUE;
         held_right = '0;
         held_left = '0;
         awaited_commands.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tmtc_pkg::CSR_BRAKE_POWER: settings.brake_power = csr_wdata;
               tmtc_pkg::CSR_MAX_REGEN_TORQUE: settings.max_regen_torque = csr_wdata;
               tmtc_pkg::CSR_REGEN_ENABLE: settings.regen_enable = csr_wdata[0];
               tmtc_pkg::CSR_MODE_SPEED_LIMIT: settings.mode_speed_limit = csr_wdata;
               tmtc_pkg::CSR_MODE_REGEN_BRAKE: settings.mode_regen_brake = csr_wdata[0];
               tmtc_pkg::CSR_CREEP_SPEED_THRESHOLD:
                  settings.creep_speed_threshold = csr_wdata;
               default: ;
            endcase
         end
         if (push && !full)
            awaited_commands.push_back(command_for_tick());
         if (pop && !empty) begin
            seen.drive_state = tmtc_pkg::drive_state_type'(rsp_drive_state);
            seen.enable_bit = rsp_enable_bit;
            seen.brake_bit = rsp_brake_bit;
            seen.run_bit = rsp_run_bit;
            seen.torque_right = rsp_torque_out_right;
            seen.torque_left = rsp_torque_out_left;
            seen.negative_torque = rsp_negative_torque;
            seen.speed_reference = rsp_speed_reference;
            if (awaited_commands.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("%0t checker: result transaction with nothing awaited", $realtime);
            end else begin
               want = awaited_commands.pop_front();
               check_field("drive_state", 16'(want.drive_state), 16'(seen.drive_state));
               check_field("enable_bit", 16'(want.enable_bit), 16'(seen.enable_bit));
               check_field("brake_bit", 16'(want.brake_bit), 16'(seen.brake_bit));
               check_field("run_bit", 16'(want.run_bit), 16'(seen.run_bit));
               check_field("torque_out_right", want.torque_right, seen.torque_right);
               check_field("torque_out_left", want.torque_left, seen.torque_left);
               check_field("negative_torque", want.negative_torque, seen.negative_torque);
               check_field("speed_reference", want.speed_reference, seen.speed_reference);
            end
         end
         outstanding <= awaited_commands.size();
      end
   end

endmodule

>>> tb/tb_traction_mode_torque_command.sv
// Testbench top for the traction mode torque command block: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_traction_mode_torque_command;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             push = 1'b0;
   logic                             full;
   logic                             req_disable_req = 1'b0;
   logic                             req_new_reference = 1'b0;
   logic [15:0]                      req_torque_in_right = '0;
   logic [15:0]                      req_torque_in_left = '0;
   logic [9:0]                       req_throttle = '0;
   logic [15:0]                      req_rear_mean_speed = '0;
   logic [15:0]                      req_motor_speed_left = '0;
   logic [15:0]                      req_motor_speed_right = '0;
   logic [15:0]                      req_wheel_speed_right = '0;
   logic [15:0]                      req_wheel_speed_left = '0;
   logic                             empty;
   logic                             pop = 1'b0;
   logic [1:0]                       rsp_drive_state;
   logic                             rsp_enable_bit;
   logic                             rsp_brake_bit;
   logic                             rsp_run_bit;
   logic [15:0]                      rsp_torque_out_right;
   logic [15:0]                      rsp_torque_out_left;
   logic [15:0]                      rsp_negative_torque;
   logic [15:0]                      rsp_speed_reference;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tmtc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]                      csr_wdata = '0;
   int                               mismatch_count;
   int                               outstanding;

   bit          calm = 1'b0;
   logic [15:0] creep_now = '0;

   traction_mode_torque_command dut (.*);

   tmtc_command_checker u_checker (.*);

   always #5 clock = ~clock;

   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_tick(input logic dis, nref, input logic [15:0] tr, tl,
                            input logic [9:0] thr, input logic [15:0] rear, ml, mr, wr, wl);
      if (!calm && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_disable_req <= dis;
      req_new_reference <= nref;
      req_torque_in_right <= tr;
      req_torque_in_left <= tl;
      req_throttle <= thr;
      req_rear_mean_speed <= rear;
      req_motor_speed_left <= ml;
      req_motor_speed_right <= mr;
      req_wheel_speed_right <= wr;
      req_wheel_speed_left <= wl;
      push <= 1'b1;
      do @(posedge clock); while (full);
   endtask

   task automatic set_registers(input logic [15:0] power, peak, input logic en,
                                input logic [15:0] limit, input logic brk,
                                input logic [15:0] creep);
      logic [15:0] value [6];
      logic [tmtc_pkg::CSR_INDEX_W-1:0] index [6];
      value = '{power, peak, 16'(en), limit, 16'(brk), creep};
      index = '{tmtc_pkg::CSR_BRAKE_POWER, tmtc_pkg::CSR_MAX_REGEN_TORQUE,
                tmtc_pkg::CSR_REGEN_ENABLE, tmtc_pkg::CSR_MODE_SPEED_LIMIT,
                tmtc_pkg::CSR_MODE_REGEN_BRAKE, tmtc_pkg::CSR_CREEP_SPEED_THRESHOLD};
      settle();
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= index[i];
         csr_wdata <= value[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      creep_now = creep;
   endtask

   function automatic logic [15:0] wide_setting();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 2000));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] wheel_sample();
      case ($urandom_range(0, 3))
         0: return creep_now + 16'($urandom_range(0, 2)) - 16'd1;
         1: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_tick();
      logic [9:0] thr;
      logic [15:0] rear, ml, mr;
      case ($urandom_range(0, 3))
         0: thr = 10'($urandom_range(0, 99));
         1: thr = 10'($urandom_range(101, 1000));
         2: thr = 10'($urandom_range(98, 102));
         default: thr = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 2))
         0: rear = 16'($urandom_range(1201, 65535));
         1: rear = 16'($urandom_range(1198, 1202));
         default: rear = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: begin ml = '0; mr = '0; end
         1: begin ml = 16'($urandom_range(1, 3000)); mr = 16'($urandom_range(0, 3000)); end
         default: begin ml = 16'($urandom); mr = 16'($urandom); end
      endcase
      send_tick($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)), 16'($urandom),
                16'($urandom), thr, rear, ml, mr, wheel_sample(), wheel_sample());
   endtask

   initial begin
      wait (!reset);
      forever begin
         if (!calm && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         pop <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_tick(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 10'd101, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b1, 16'hFFFF, 16'h0000, 10'd101, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd1023, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b1, 16'h1234, 16'hABCD, 10'd100, 16'hFFFF, 16'd0, 16'd0, 16'd0,
                16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd101, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd99, 16'hFFFF, 16'd5, 16'd5, 16'd1,
                16'd0);
      send_tick(1'b0, 1'b1, 16'h0000, 16'hFFFF, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);

      set_registers(16'd30000, 16'd1000, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0, 16'd1201, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd99, 16'd1200, 16'd0, 16'd0, 16'hFFFF,
                16'hFFFF);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b1, 16'h7777, 16'h8888, 10'd50, 16'd5000, 16'd65534, 16'hFFFF,
                16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd100, 16'd2000, 16'd100, 16'd100, 16'd0,
                16'd0);
      send_tick(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 10'd1000, 16'd2000, 16'd0, 16'd0, 16'd0,
                16'd0);
      send_tick(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 10'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd50, 16'd3000, 16'd3000, 16'd0, 16'd0,
                16'd0);

      set_registers(16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 16'h0000);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd10, 16'hFFFF, 16'd1, 16'd1, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
                16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd10, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b1, 16'h5555, 16'hAAAA, 10'd101, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd100, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0);

      set_registers(16'h0000, 16'h0000, 1'b1, 16'd700, 1'b1, 16'd10);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd10, 16'hFFFF, 16'd7, 16'd0, 16'd0, 16'd0);
      send_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd10, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);

      for (int phase = 0; phase < 6; phase++) begin
         set_registers(wide_setting(), wide_setting(), $urandom_range(0, 3) != 0,
                       wide_setting(), 1'($urandom_range(0, 1)), wide_setting());
         calm = (phase == 5);
         repeat (250) random_tick();
      end

      settle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb_traction_mode_torque_command: clean");
      else
         $display("tb_traction_mode_torque_command: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_traction_mode_torque_command: errors");
      $finish;
   end

endmodule
